// File: design/wcts_pkg.sv
// shared constants, types and helpers of the wall column texel stepper
`default_nettype none

package wcts_pkg;

   localparam int SCREEN_ROWS     = 1024;
   localparam int MAX_TEX_SIZE    = 1024;
   localparam int BYTES_PER_TEXEL = 4;

   localparam int FRAC_W      = 16;
   localparam int LH_W        = 16;
   localparam int TEXEL_W     = 10;
   localparam int DIM_W       = 11;
   localparam int ROW_W       = 10;
   localparam int END_W       = 11;
   localparam int OFFSET_W    = 22;
   localparam int POS_W       = 40;
   localparam int STEP_W      = DIM_W + FRAC_W;
   localparam int DIV_COUNT_W = $clog2(STEP_W);
   localparam int BASE_W      = 18;
   localparam int CSR_INDEX_W = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_ROW   = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      FACE_NORTH = 2'd0,
      FACE_SOUTH = 2'd1,
      FACE_EAST  = 2'd2,
      FACE_WEST  = 2'd3
   } face_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NORTH_WIDTH  = 4'd0,
      CSR_NORTH_HEIGHT = 4'd1,
      CSR_SOUTH_WIDTH  = 4'd2,
      CSR_SOUTH_HEIGHT = 4'd3,
      CSR_EAST_WIDTH   = 4'd4,
      CSR_EAST_HEIGHT  = 4'd5,
      CSR_WEST_WIDTH   = 4'd6,
      CSR_WEST_HEIGHT  = 4'd7
   } csr_index_type;

   typedef enum logic {
      BACK_FETCH  = 1'b0,
      BACK_DIVIDE = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } dims_type;

   typedef struct packed {
      action_type         action;
      face_type           face;
      logic [TEXEL_W-1:0] texel_x;
      logic [LH_W-1:0]    column_height;
      logic [ROW_W-1:0]   first_row;
      logic [END_W-1:0]   end_row;
      logic [DIM_W-1:0]   height;
   } queue_entry_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (v > DIM_W'(MAX_TEX_SIZE)) begin
         return DIM_W'(MAX_TEX_SIZE);
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// File: design/wcts_channels.sv
// request, response and register write channel interfaces
`default_nettype none

interface wcts_req_if import wcts_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic               hit_side;
   logic               dir_x_negative;
   logic               dir_y_positive;
   logic [FRAC_W-1:0]  wall_frac;
   logic [LH_W-1:0]    column_height;
   logic [ROW_W-1:0]   first_row;
   logic [END_W-1:0]   end_row;

   modport source (output valid, action, hit_side, dir_x_negative, dir_y_positive,
                   wall_frac, column_height, first_row, end_row, input ready);
   modport sink (input valid, action, hit_side, dir_x_negative, dir_y_positive,
                 wall_frac, column_height, first_row, end_row, output ready);
endinterface

interface wcts_rsp_if import wcts_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          face;
   logic [TEXEL_W-1:0]  texel_x;
   logic [TEXEL_W-1:0]  texel_y;
   logic [OFFSET_W-1:0] texel_byte_offset;
   logic [ROW_W-1:0]    screen_row;
   logic                last_row;

   modport source (output valid, face, texel_x, texel_y, texel_byte_offset, screen_row,
                   last_row, input ready);
   modport sink (input valid, face, texel_x, texel_y, texel_byte_offset, screen_row,
                 last_row, output ready);
endinterface

interface wcts_csr_if import wcts_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DIM_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/wcts_front.sv
// front end: size registers, face choice, texel column and request classification
`default_nettype none

module wcts_front import wcts_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   wcts_req_if.sink       req_ch,
   wcts_csr_if.sink       csr_ch,
   output queue_entry_type push_entry,
   output logic           push_valid,
   input  wire logic      push_ready,
   output dims_type [3:0] dims
);

   logic [DIM_W-1:0] width_ff  [4];
   logic [DIM_W-1:0] width_in  [4];
   logic [DIM_W-1:0] height_ff [4];
   logic [DIM_W-1:0] height_in [4];

   face_type          face;
   logic [DIM_W-1:0]  face_width;
   logic [STEP_W-1:0] frac_prod;
   logic [DIM_W-1:0]  tx_raw;
   logic [DIM_W-1:0]  tx_mirror;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         width_in[i]  = width_ff[i];
         height_in[i] = height_ff[i];
      end
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_NORTH_WIDTH:  width_in[FACE_NORTH]  = csr_ch.data;
            CSR_NORTH_HEIGHT: height_in[FACE_NORTH] = csr_ch.data;
            CSR_SOUTH_WIDTH:  width_in[FACE_SOUTH]  = csr_ch.data;
            CSR_SOUTH_HEIGHT: height_in[FACE_SOUTH] = csr_ch.data;
            CSR_EAST_WIDTH:   width_in[FACE_EAST]   = csr_ch.data;
            CSR_EAST_HEIGHT:  height_in[FACE_EAST]  = csr_ch.data;
            CSR_WEST_WIDTH:   width_in[FACE_WEST]   = csr_ch.data;
            CSR_WEST_HEIGHT:  height_in[FACE_WEST]  = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            width_ff[i]  <= DIM_RESET;
            height_ff[i] <= DIM_RESET;
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            width_ff[i]  <= width_in[i];
            height_ff[i] <= height_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dims[i].width  = clamp_dim(width_ff[i]);
         dims[i].height = clamp_dim(height_ff[i]);
      end
   end

   always_comb begin
      if (!req_ch.hit_side) begin
         face = req_ch.dir_x_negative ? FACE_NORTH : FACE_SOUTH;
      end else begin
         face = req_ch.dir_y_positive ? FACE_EAST : FACE_WEST;
      end
      face_width = dims[face].width;
      frac_prod  = STEP_W'(req_ch.wall_frac) * STEP_W'(face_width);
      tx_raw     = frac_prod[STEP_W-1:FRAC_W];
      tx_mirror  = face_width - tx_raw - DIM_W'(1);

      push_entry.action  = action_type'(req_ch.action);
      push_entry.face    = face;
      push_entry.height  = dims[face].height;
      // north and east faces read the texture mirrored
      if (face == FACE_NORTH || face == FACE_EAST) begin
         push_entry.texel_x = tx_mirror[TEXEL_W-1:0];
      end else begin
         push_entry.texel_x = tx_raw[TEXEL_W-1:0];
      end
      push_entry.column_height = (req_ch.column_height == '0) ? LH_W'(1)
                                                              : req_ch.column_height;
      push_entry.first_row   = req_ch.first_row;
      if (req_ch.end_row > END_W'(SCREEN_ROWS)) begin
         push_entry.end_row = END_W'(SCREEN_ROWS);
      end else begin
         push_entry.end_row = req_ch.end_row;
      end
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

`default_nettype wire

// File: design/wcts_queue.sv
// short request queue between the front and back ends
`default_nettype none

module wcts_queue import wcts_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire queue_entry_type push_entry,
   input  wire logic            push_valid,
   output logic                 push_ready,
   output queue_entry_type      head_entry,
   output logic                 head_valid,
   input  wire logic            pop
);

   queue_entry_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]    wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_in;
   logic [QUEUE_PTR_W:0]      count_ff;
   logic [QUEUE_PTR_W:0]      count_in;
   logic                      push_fire;
   logic                      pop_fire;

   assign push_ready = count_ff < (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop && head_valid;

   // depth is a power of two, so the pointers wrap on their own
   always_comb begin
      wr_ptr_in = push_fire ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (!push_fire && pop_fire) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: design/wcts_divider.sv
// restoring divider, one quotient bit per cycle, for the texture step
`default_nettype none

module wcts_divider import wcts_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [STEP_W-1:0] dividend,
   input  wire logic [LH_W-1:0]   divisor,
   output logic                   done,
   output logic [STEP_W-1:0]      quotient
);

   logic [LH_W-1:0]        rem_ff;
   logic [LH_W-1:0]        rem_in;
   logic [STEP_W-1:0]      quo_ff;
   logic [STEP_W-1:0]      quo_in;
   logic [LH_W-1:0]        div_ff;
   logic [LH_W-1:0]        div_in;
   logic [DIV_COUNT_W-1:0] count_ff;
   logic [DIV_COUNT_W-1:0] count_in;
   logic                   busy_ff;
   logic                   busy_in;
   logic                   done_ff;
   logic                   done_in;
   logic [LH_W:0]          rem_shift;
   logic [LH_W:0]          rem_diff;

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      // dividend bits shift out of the top of the quotient register
      rem_shift = {rem_ff, quo_ff[STEP_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
         count_in = DIV_COUNT_W'(STEP_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!rem_diff[LH_W]) begin
            rem_in = rem_diff[LH_W-1:0];
            quo_in = {quo_ff[STEP_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[LH_W-1:0];
            quo_in = {quo_ff[STEP_W-2:0], 1'b0};
         end
         count_in = count_ff - DIV_COUNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: design/wcts_back.sv
// back end: column state, step and seed, per-row texel address and response register
`default_nettype none

module wcts_back import wcts_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dims_type [3:0]  dims,
   input  wire queue_entry_type head_entry,
   input  wire logic            head_valid,
   output logic                 pop,
   wcts_rsp_if.source           rsp_ch
);

   back_state_type      state_ff;
   back_state_type      state_in;

   logic                active_ff;
   logic                active_in;
   face_type            face_ff;
   face_type            face_in;
   logic [TEXEL_W-1:0]  texel_x_ff;
   logic [TEXEL_W-1:0]  texel_x_in;
   logic [LH_W-1:0]     lh_ff;
   logic [LH_W-1:0]     lh_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [END_W-1:0]    cur_row_ff;
   logic [END_W-1:0]    cur_row_in;
   logic [END_W-1:0]    stop_row_ff;
   logic [END_W-1:0]    stop_row_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   face_type            rsp_face_ff;
   face_type            rsp_face_in;
   logic [TEXEL_W-1:0]  rsp_texel_x_ff;
   logic [TEXEL_W-1:0]  rsp_texel_x_in;
   logic [TEXEL_W-1:0]  rsp_texel_y_ff;
   logic [TEXEL_W-1:0]  rsp_texel_y_in;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [OFFSET_W-1:0] rsp_offset_in;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [ROW_W-1:0]    rsp_row_in;
   logic                rsp_last_ff;
   logic                rsp_last_in;

   logic                div_start;
   logic                div_done;
   logic [STEP_W-1:0]   div_quotient;

   logic                          out_free;
   logic [DIM_W-1:0]              row_width;
   logic [DIM_W-1:0]              row_height_m1;
   logic [POS_W-1:0]              pos_neg;
   logic [POS_W-FRAC_W-1:0]       mag_neg;
   logic [TEXEL_W-1:0]            ty;
   logic [OFFSET_W-1:0]           offset_sum;
   logic [END_W:0]                row_next;
   logic                          row_last;
   logic signed [BASE_W-1:0]      seed_base;
   logic signed [BASE_W+STEP_W:0] seed_prod;

   wcts_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({head_entry.height, FRAC_W'(0)}),
      .divisor  (head_entry.column_height),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // texel row: truncate the signed position toward zero, then mask
   always_comb begin
      row_width     = dims[face_ff].width;
      row_height_m1 = dims[face_ff].height - DIM_W'(1);
      pos_neg       = '0 - pos_ff;
      mag_neg       = '0 - pos_neg[POS_W-1:FRAC_W];
      if (pos_ff[POS_W-1]) begin
         ty = mag_neg[TEXEL_W-1:0] & row_height_m1[TEXEL_W-1:0];
      end else begin
         ty = pos_ff[FRAC_W+TEXEL_W-1:FRAC_W] & row_height_m1[TEXEL_W-1:0];
      end
      offset_sum = OFFSET_W'(row_width) * OFFSET_W'(ty) + OFFSET_W'(texel_x_ff);
      row_next   = {1'b0, cur_row_ff} + (END_W + 1)'(1);
      row_last   = row_next >= {1'b0, stop_row_ff};
   end

   // seed = (first row - half screen + half line height) * step
   always_comb begin
      seed_base = $signed(BASE_W'(cur_row_ff)) - $signed(BASE_W'(SCREEN_ROWS / 2))
                  + $signed(BASE_W'(lh_ff >> 1));
      seed_prod = seed_base * $signed({1'b0, div_quotient});
   end

   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      face_in     = face_ff;
      texel_x_in  = texel_x_ff;
      lh_in       = lh_ff;
      step_in     = step_ff;
      pos_in      = pos_ff;
      cur_row_in  = cur_row_ff;
      stop_row_in = stop_row_ff;

      out_free       = !rsp_valid_ff || rsp_ch.ready;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_face_in    = rsp_face_ff;
      rsp_texel_x_in = rsp_texel_x_ff;
      rsp_texel_y_in = rsp_texel_y_ff;
      rsp_offset_in  = rsp_offset_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_last_in    = rsp_last_ff;

      pop       = 1'b0;
      div_start = 1'b0;

      case (state_ff)
         BACK_FETCH: begin
            if (head_valid) begin
               if (head_entry.action == ACTION_START) begin
                  pop         = 1'b1;
                  div_start   = 1'b1;
                  face_in     = head_entry.face;
                  texel_x_in  = head_entry.texel_x;
                  lh_in       = head_entry.column_height;
                  cur_row_in  = END_W'(head_entry.first_row);
                  stop_row_in = head_entry.end_row;
                  active_in   = END_W'(head_entry.first_row) < head_entry.end_row;
                  state_in    = BACK_DIVIDE;
               end else if (!active_ff) begin
                  // next row with no column left: dropped
                  pop = 1'b1;
               end else if (out_free) begin
                  pop            = 1'b1;
                  rsp_valid_in   = 1'b1;
                  rsp_face_in    = face_ff;
                  rsp_texel_x_in = texel_x_ff;
                  rsp_texel_y_in = ty;
                  rsp_offset_in  = OFFSET_W'(offset_sum * OFFSET_W'(BYTES_PER_TEXEL));
                  rsp_row_in     = cur_row_ff[ROW_W-1:0];
                  rsp_last_in    = row_last;
                  pos_in         = pos_ff + POS_W'(step_ff);
                  cur_row_in     = row_next[END_W-1:0];
                  if (row_last) begin
                     active_in = 1'b0;
                  end
               end
            end
         end
         BACK_DIVIDE: begin
            if (div_done) begin
               step_in  = div_quotient;
               pos_in   = seed_prod[POS_W-1:0];
               state_in = BACK_FETCH;
            end
         end
         default: state_in = BACK_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_FETCH;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      face_ff        <= face_in;
      texel_x_ff     <= texel_x_in;
      lh_ff          <= lh_in;
      step_ff        <= step_in;
      pos_ff         <= pos_in;
      cur_row_ff     <= cur_row_in;
      stop_row_ff    <= stop_row_in;
      rsp_face_ff    <= rsp_face_in;
      rsp_texel_x_ff <= rsp_texel_x_in;
      rsp_texel_y_ff <= rsp_texel_y_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.face              = rsp_face_ff;
   assign rsp_ch.texel_x           = rsp_texel_x_ff;
   assign rsp_ch.texel_y           = rsp_texel_y_ff;
   assign rsp_ch.texel_byte_offset = rsp_offset_ff;
   assign rsp_ch.screen_row        = rsp_row_ff;
   assign rsp_ch.last_row          = rsp_last_ff;

endmodule

`default_nettype wire

// File: design/wall_column_texel_stepper.sv
// Wall column texel stepper. A start request picks the wall face and its texture size,
// mirrors the texel column for north and east faces and derives a Q11.16 step (texture
// height / line height) and the seeded texture position; each next-row request of an
// active column then yields one texel address and its screen row. The front end takes
// a request in any cycle the four-entry queue has room. A next-row request at the queue
// head goes to the response register once it is free, one per clock while the response
// is taken. A start request holds the back end through the divide issue, the restoring
// divider at one bit per cycle and the seed multiply. Size registers reset to 64 and are
// written through the register port, which is always ready.
`default_nettype none

module wall_column_texel_stepper import wcts_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   wcts_req_if.sink   req_ch,
   wcts_rsp_if.source rsp_ch,
   wcts_csr_if.sink   csr_ch
);

   queue_entry_type push_entry;
   logic            push_valid;
   logic            push_ready;
   queue_entry_type head_entry;
   logic            head_valid;
   logic            pop;
   dims_type [3:0]  dims;

   wcts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .dims       (dims)
   );

   wcts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .pop        (pop)
   );

   wcts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .dims       (dims),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire
